@@ rtl/mfr_pkg.sv @@
// Types and constants shared by the multidrop frame receiver.
package mfr_pkg;

   localparam int unsigned FRAME_BYTES = 5;
   localparam int unsigned POS_WIDTH   = 3;

   localparam logic [1:0] CSR_OWN_ADDRESS       = 2'd0;
   localparam logic [1:0] CSR_BROADCAST_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_LOW_SPEED_MODE    = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       ninth_bit;
      logic       line_error;
   } mfr_req_type;

   typedef struct packed {
      logic [7:0] address_byte;
      logic [7:0] data_byte_one;
      logic [7:0] data_byte_two;
      logic [7:0] data_byte_three;
      logic [7:0] data_byte_four;
      logic       checksum_ok;
      logic       address_accepted;
   } mfr_rsp_type;

endpackage

@@ rtl/multidrop_frame_receiver.sv @@
// Nine-bit multidrop UART frame receiver: top level with framing and checksum logic.
// A request is held in the input register; the checksum byte's result is on rsp_valid
// from the edge where it leaves that register. Throughput: one request per cycle while
// the result side does not stall, as each byte's add and compare is combinational.
// Reset (synchronous, active high) clears the valid flags, frame state and CSRs.
module multidrop_frame_receiver (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mfr_pkg::mfr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mfr_pkg::mfr_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata
);

   // Configuration registers.
   logic [7:0] own_addr_ff;
   logic [7:0] bcast_addr_ff;
   logic       low_speed_ff;

   // Input register holding one request ahead of the framing logic.
   logic                 in_valid_ff;
   logic                 in_valid_in;
   mfr_pkg::mfr_req_type in_data_ff;

   // Frame state.
   logic                          active_ff, active_in;
   logic [mfr_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]                    sum_ff, sum_in;
   logic [7:0]                    store_ff [mfr_pkg::FRAME_BYTES];

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   mfr_pkg::mfr_rsp_type rsp_data_ff, rsp_data_in;

   logic advance;   // the input register hands its request to the framing logic
   logic process;   // a buffered request is being processed this cycle
   logic store_we;
   logic rsp_load;

   // The input stage may only move on when the result register can take a new
   // result. Since a result is produced by at most one request, this keeps
   // the pipeline lossless while still allowing one request per cycle.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign process   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff   <= 8'd0;
         bcast_addr_ff <= 8'd0;
         low_speed_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            mfr_pkg::CSR_OWN_ADDRESS:       own_addr_ff   <= csr_wdata;
            mfr_pkg::CSR_BROADCAST_ADDRESS: bcast_addr_ff <= csr_wdata;
            mfr_pkg::CSR_LOW_SPEED_MODE:    low_speed_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Framing decisions for the buffered request. A line error wins over
   // everything; low-speed mode then ignores the byte; an address byte always
   // restarts a frame; data bytes fill the frame until the checksum byte.
   always_comb begin
      active_in   = active_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      store_we    = 1'b0;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      if (process) begin
         if (in_data_ff.line_error) begin
            active_in = 1'b0;
            pos_in    = '0;
            sum_in    = 8'd0;
         end else if (!low_speed_ff) begin
            if (in_data_ff.ninth_bit) begin
               active_in = 1'b1;
               pos_in    = mfr_pkg::POS_WIDTH'(1);
               sum_in    = in_data_ff.rx_byte;
               store_we  = 1'b1;
            end else if (active_ff) begin
               if (pos_ff < mfr_pkg::POS_WIDTH'(mfr_pkg::FRAME_BYTES)) begin
                  pos_in   = pos_ff + mfr_pkg::POS_WIDTH'(1);
                  sum_in   = sum_ff + in_data_ff.rx_byte;
                  store_we = 1'b1;
               end else begin
                  // Checksum byte closes the frame; the position stays at
                  // the full count until the next address byte or line error.
                  active_in = 1'b0;
                  rsp_load  = 1'b1;
                  rsp_data_in.address_byte     = store_ff[0];
                  rsp_data_in.data_byte_one    = store_ff[1];
                  rsp_data_in.data_byte_two    = store_ff[2];
                  rsp_data_in.data_byte_three  = store_ff[3];
                  rsp_data_in.data_byte_four   = store_ff[4];
                  rsp_data_in.checksum_ok      = (sum_ff == in_data_ff.rx_byte);
                  rsp_data_in.address_accepted = (store_ff[0] == own_addr_ff) ||
                                                 (store_ff[0] == bcast_addr_ff);
               end
            end
         end
      end
   end

   // The address byte is written at entry zero; data bytes at the current
   // position, which is below the frame length whenever they are stored.
   always_ff @(posedge clock) begin
      if (store_we) begin
         if (in_data_ff.ninth_bit) begin
            store_ff[0] <= in_data_ff.rx_byte;
         end else begin
            store_ff[pos_ff] <= in_data_ff.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         sum_ff    <= 8'd0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
      end
   end

   // The result register is free or being drained whenever a result loads.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_only_full_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (active_ff && pos_ff == mfr_pkg::POS_WIDTH'(mfr_pkg::FRAME_BYTES)))
      else $error("result produced from an incomplete frame");

   a_active_pos_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (pos_ff != '0 &&
                     pos_ff <= mfr_pkg::POS_WIDTH'(mfr_pkg::FRAME_BYTES)))
      else $error("open frame with an impossible byte position");

   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("buffered request lost while the result side stalled");

   a_line_error_drops: assert property (@(posedge clock) disable iff (reset)
      (process && in_data_ff.line_error) |=> (!active_ff && pos_ff == '0 && sum_ff == 8'd0))
      else $error("line error did not drop the frame");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !rsp_load)
      else $error("pending result overwritten");
`endif

endmodule

@@ verif/multidrop_frame_receiver_tb.sv @@
// Self-checking testbench for the nine-bit multidrop frame receiver.
module multidrop_frame_receiver_tb;

   // The run is ended as a failure if it ever gets this far.
   localparam int unsigned CYCLE_LIMIT   = 250000;
   // The receiver holds a request in its input register and presents its result as the
   // request leaves it, so these spare cycles are plenty to let anything in flight settle.
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned IDLE_PERCENT  = 38;
   localparam int unsigned PHASE_REQUESTS = 240;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   mfr_pkg::mfr_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   mfr_pkg::mfr_rsp_type rsp_data;
   logic                 csr_we;
   logic [1:0]           csr_index;
   logic [7:0]           csr_wdata;

   multidrop_frame_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Our own copy of the receiver's registers and framing state. Framing state is updated
   // once per accepted request, in acceptance order, so it tracks the hardware exactly.
   logic [7:0] own_addr;
   logic [7:0] bcast_addr;
   logic       low_speed;
   logic       frame_open;
   logic [2:0] byte_count;
   logic [7:0] frame_sum;
   logic [7:0] frame_bytes [mfr_pkg::FRAME_BYTES];

   // Completed frames that the receiver still owes us, oldest first.
   mfr_pkg::mfr_rsp_type expected_frames [$];

   int unsigned errors;
   int unsigned cycles;
   int unsigned requests_sent;
   // When set, neither side inserts idle cycles.
   bit          steady_flow;

   always #10 clock = ~clock;

   // Watchdog: a hung handshake must not leave the simulation running forever.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The result side stalls at random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want != got) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Every result taken from the receiver is compared against the oldest completed frame.
   always @(posedge clock) begin : result_checker
      mfr_pkg::mfr_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
         end else begin
            want = expected_frames.pop_front();
            check_field("address_byte", want.address_byte, rsp_data.address_byte);
            check_field("data_byte_one", want.data_byte_one, rsp_data.data_byte_one);
            check_field("data_byte_two", want.data_byte_two, rsp_data.data_byte_two);
            check_field("data_byte_three", want.data_byte_three, rsp_data.data_byte_three);
            check_field("data_byte_four", want.data_byte_four, rsp_data.data_byte_four);
            check_field("checksum_ok", 8'(want.checksum_ok), 8'(rsp_data.checksum_ok));
            check_field("address_accepted", 8'(want.address_accepted),
                        8'(rsp_data.address_accepted));
         end
      end
   end

   // Advances our framing state by one received character and queues a result when the
   // checksum character closes a frame.
   task automatic track_character(input mfr_pkg::mfr_req_type item);
      mfr_pkg::mfr_rsp_type done;
      if (item.line_error) begin
         // A line error wins over everything, even in low-speed mode.
         frame_open = 1'b0;
         byte_count = '0;
         frame_sum  = '0;
      end else if (low_speed) begin
         // Nine-bit framing is off; the character is dropped and nothing changes.
      end else if (item.ninth_bit) begin
         // An address character always starts a fresh frame, abandoning any open one.
         frame_bytes[0] = item.rx_byte;
         frame_sum      = item.rx_byte;
         byte_count     = 3'd1;
         frame_open     = 1'b1;
      end else if (!frame_open) begin
         // Data with no frame open is ignored.
      end else if (byte_count < mfr_pkg::FRAME_BYTES) begin
         frame_bytes[byte_count] = item.rx_byte;
         frame_sum  = frame_sum + item.rx_byte;
         byte_count = byte_count + 3'd1;
      end else begin
         // This is the checksum character; the frame closes and a result is owed.
         frame_open             = 1'b0;
         done.address_byte      = frame_bytes[0];
         done.data_byte_one     = frame_bytes[1];
         done.data_byte_two     = frame_bytes[2];
         done.data_byte_three   = frame_bytes[3];
         done.data_byte_four    = frame_bytes[4];
         done.checksum_ok       = (frame_sum == item.rx_byte);
         done.address_accepted  = (frame_bytes[0] == own_addr) ||
                                  (frame_bytes[0] == bcast_addr);
         expected_frames.push_back(done);
      end
   endtask

   function automatic mfr_pkg::mfr_req_type character(input logic [7:0] value,
                                                      input logic ninth,
                                                      input logic err);
      mfr_pkg::mfr_req_type item;
      item.rx_byte    = value;
      item.ninth_bit  = ninth;
      item.line_error = err;
      return item;
   endfunction

   // Presents one request and returns once it has been accepted. Valid is only lowered
   // when an idle gap comes before this request, so back-to-back requests keep it high.
   task automatic send_request(input mfr_pkg::mfr_req_type item);
      int unsigned gap;
      gap = 0;
      if (!steady_flow)
         while ($urandom_range(99) < IDLE_PERCENT)
            gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      requests_sent++;
      track_character(item);
   endtask

   // Sends an address character, four data characters and a checksum character. With
   // bad_sum set, the checksum is pushed off the true sum by a nonzero amount.
   task automatic send_frame(input logic [7:0] addr, input logic [31:0] payload,
                             input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] value;
      sum = addr;
      send_request(character(addr, 1'b1, 1'b0));
      for (int k = 0; k < 4; k++) begin
         value = payload[31 - 8 * k -: 8];
         sum   = sum + value;
         send_request(character(value, 1'b0, 1'b0));
      end
      if (bad_sum)
         sum = sum + 8'($urandom_range(255, 1));
      send_request(character(sum, 1'b0, 1'b0));
   endtask

   // Drops valid and waits until every owed result has come back and the pipeline has
   // had time to swallow any request that produces no result.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (index)
         mfr_pkg::CSR_OWN_ADDRESS:       own_addr   = value;
         mfr_pkg::CSR_BROADCAST_ADDRESS: bcast_addr = value;
         mfr_pkg::CSR_LOW_SPEED_MODE:    low_speed  = value[0];
         default: ;
      endcase
   endtask

   task automatic set_addresses(input logic [7:0] own, input logic [7:0] bcast);
      write_csr(mfr_pkg::CSR_OWN_ADDRESS, own);
      write_csr(mfr_pkg::CSR_BROADCAST_ADDRESS, bcast);
   endtask

   // With both addresses at their reset value of zero, an all-zero frame is accepted
   // and its checksum matches.
   task automatic test_reset_values();
      send_frame(8'h00, 32'h0000_0000, 1'b0);
      wait_idle();
   endtask

   // Broadcast frame whose sum wraps past 255, a stray data byte after the frame ends,
   // and a frame for another node with a corrupted checksum.
   task automatic test_frame_content();
      set_addresses(8'h5A, 8'hFF);
      send_frame(8'hFF, 32'hFFFF_FFFF, 1'b0);
      send_request(character(8'hA5, 1'b0, 1'b0));
      send_frame(8'h33, 32'h0102_0304, 1'b1);
      wait_idle();
   endtask

   // A line error kills an open frame even when it carries the ninth bit, data after it is
   // dropped, and an address character arriving in the checksum slot restarts the frame.
   task automatic test_frame_aborts();
      send_request(character(8'h12, 1'b1, 1'b0));
      send_request(character(8'h01, 1'b0, 1'b0));
      send_request(character(8'h80, 1'b1, 1'b1));
      send_request(character(8'h02, 1'b0, 1'b0));
      send_request(character(8'h5A, 1'b1, 1'b0));
      for (int k = 0; k < 4; k++)
         send_request(character(8'(8'h10 << k), 1'b0, 1'b0));
      send_frame(8'h5A, 32'h8040_2010, 1'b0);
      wait_idle();
   endtask

   // Low-speed mode freezes an open frame without clearing it; the frame then completes
   // once nine-bit framing is back on. A line error still clears state in low-speed mode.
   task automatic test_low_speed();
      send_request(character(8'h77, 1'b1, 1'b0));
      send_request(character(8'h10, 1'b0, 1'b0));
      wait_idle();
      write_csr(mfr_pkg::CSR_LOW_SPEED_MODE, 8'h01);
      send_request(character(8'h20, 1'b1, 1'b0));
      send_request(character(8'h30, 1'b0, 1'b0));
      wait_idle();
      write_csr(mfr_pkg::CSR_LOW_SPEED_MODE, 8'h00);
      send_request(character(8'h40, 1'b0, 1'b0));
      send_request(character(8'h50, 1'b0, 1'b0));
      send_request(character(8'h60, 1'b0, 1'b0));
      send_request(character(8'h77, 1'b0, 1'b0));
      send_request(character(8'h01, 1'b1, 1'b0));
      wait_idle();
      write_csr(mfr_pkg::CSR_LOW_SPEED_MODE, 8'h01);
      send_request(character(8'h00, 1'b0, 1'b1));
      wait_idle();
      write_csr(mfr_pkg::CSR_LOW_SPEED_MODE, 8'h00);
      send_request(character(8'h11, 1'b0, 1'b0));
      wait_idle();
   endtask

   // One randomly chosen burst: mostly complete frames with random content, the rest
   // truncated frames, stray characters and line errors.
   task automatic random_burst();
      int unsigned pick;
      int unsigned length;
      logic [7:0]  addr;
      pick = $urandom_range(99);
      case ($urandom_range(2))
         0:       addr = own_addr;
         1:       addr = bcast_addr;
         default: addr = 8'($urandom_range(255));
      endcase
      if (pick < 70) begin
         send_frame(addr, $urandom, $urandom_range(3) == 0);
      end else if (pick < 82) begin
         length = $urandom_range(4);
         send_request(character(addr, 1'b1, 1'b0));
         repeat (length)
            send_request(character(8'($urandom_range(255)), 1'b0, 1'b0));
         if ($urandom_range(1) == 1)
            send_request(character(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1));
      end else if (pick < 95) begin
         send_request(character(8'($urandom_range(255)), $urandom_range(3) == 0,
                                $urandom_range(7) == 0));
      end else begin
         send_request(character(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1));
      end
   endtask

   // Several phases, each with its own pair of addresses, the extremes first. One phase
   // runs with no idle cycles on either side.
   task automatic test_random_traffic();
      int unsigned target;
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0:       set_addresses(8'h00, 8'h00);
            1:       set_addresses(8'hFF, 8'hFF);
            2:       set_addresses(8'h00, 8'hFF);
            default: set_addresses(8'($urandom_range(255)), 8'($urandom_range(255)));
         endcase
         steady_flow = (phase == 5);
         target = requests_sent + PHASE_REQUESTS;
         while (requests_sent < target)
            random_burst();
      end
      steady_flow = 1'b0;
      wait_idle();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = mfr_pkg::CSR_OWN_ADDRESS;
      csr_wdata     = '0;
      errors        = 0;
      cycles        = 0;
      requests_sent = 0;
      steady_flow   = 1'b0;
      own_addr      = '0;
      bcast_addr    = '0;
      low_speed     = 1'b0;
      frame_open    = 1'b0;
      byte_count    = '0;
      frame_sum     = '0;
      foreach (frame_bytes[k])
         frame_bytes[k] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_frame_content();
      test_frame_aborts();
      test_low_speed();
      test_random_traffic();

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
